// ----- design/psi_pkg.sv -----
// Shared types and constants for the power sequence interpreter.
// Used by psi_eval, psi_seq and the top level; depends on nothing.
package psi_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int POS_W       = IDX_W + 1;
  localparam int WAIT_W      = 26;
  localparam int DELAY_SCALE = 1000;

  localparam logic [7:0]  CUT_RESET       = 8'd255;
  localparam logic [7:0]  FAB_RESET       = 8'd255;
  localparam logic [7:0]  INTF_RESET      = 8'd255;
  localparam logic [15:0] POLL_LIMIT_RESET = 16'd5000;
  localparam logic [9:0]  POLL_WAIT_RESET  = 10'd10;

  // command codes
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_RDATA = 2'd2;
  localparam logic [1:0] CMD_TICK  = 2'd3;

  // entry op codes
  localparam logic [2:0] OP_READ  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_POLL  = 3'd2;
  localparam logic [2:0] OP_DELAY = 3'd3;
  localparam logic [2:0] OP_END   = 3'd4;

  // result action codes
  localparam logic [2:0] ACT_READ    = 3'd0;
  localparam logic [2:0] ACT_WRITE   = 3'd1;
  localparam logic [2:0] ACT_DONE    = 3'd2;
  localparam logic [2:0] ACT_TIMEOUT = 3'd3;
  localparam logic [2:0] ACT_OVERRUN = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_CUT_VERSION     = 3'd0;
  localparam logic [2:0] REG_FAB_VERSION     = 3'd1;
  localparam logic [2:0] REG_HOST_INTF       = 3'd2;
  localparam logic [2:0] REG_POLL_LIMIT      = 3'd3;
  localparam logic [2:0] REG_POLL_WAIT_TICKS = 3'd4;

  typedef struct packed {
    logic [15:0] offset;
    logic [7:0]  cut;
    logic [7:0]  fab;
    logic [7:0]  intf;
    logic [2:0]  op;
    logic [7:0]  mask;
    logic [7:0]  value;
  } entry_t;

  typedef struct packed {
    logic [7:0]  cut_version;
    logic [7:0]  fab_version;
    logic [7:0]  host_intf;
    logic [15:0] poll_limit;
    logic [9:0]  poll_wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] command;
    logic [7:0] read_data;
  } req_t;

  typedef struct packed {
    logic              match;
    logic [7:0]        merged;
    logic              hit;
    logic [WAIT_W-1:0] delay_ticks;
  } eval_t;

endpackage

// ----- design/psi_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module psi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/psi_eval.sv -----
// Entry evaluation unit: version match, read-modify merge, poll compare, delay length.
// Depends on psi_pkg.
module psi_eval (
  input  psi_pkg::entry_t entry,
  input  psi_pkg::cfg_t   cfg,
  input  logic [7:0]      rdata,
  output psi_pkg::eval_t  ev
);
  import psi_pkg::*;

  always_comb begin
    ev.match  = (|(entry.cut & cfg.cut_version)) && (|(entry.fab & cfg.fab_version))
             && (|(entry.intf & cfg.host_intf));
    ev.merged = (rdata & ~entry.mask) | (entry.value & entry.mask);
    ev.hit    = (rdata & entry.mask) == (entry.value & entry.mask);
    // microsecond mode when value is zero, else scaled
    if (entry.value == 8'd0) begin
      ev.delay_ticks = WAIT_W'(entry.offset);
    end else begin
      ev.delay_ticks = WAIT_W'(entry.offset) * WAIT_W'(DELAY_SCALE);
    end
  end

endmodule

// ----- design/psi_seq.sv -----
// Sequencer: walks the table one entry per fetch/evaluate pair, tracks phase,
// poll count and wait timer, and registers the result. Depends on psi_pkg, psi_eval.
module psi_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  psi_pkg::req_t              req,
  input  psi_pkg::cfg_t              cfg,
  input  psi_pkg::entry_t            entry,
  output logic [psi_pkg::IDX_W-1:0]  raddr,
  output logic                       busy,
  output logic                       out_valid,
  output logic [2:0]                 out_action,
  output logic [15:0]                out_address,
  output logic [7:0]                 out_write_data
);
  import psi_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_EVAL} state_t;
  typedef enum logic [2:0] {PH_IDLE, PH_RUN, PH_WREAD, PH_PREAD, PH_PWAIT, PH_DELAY} phase_t;
  typedef enum logic [1:0] {MD_SCAN, MD_RDATA, MD_PREREAD} mode_t;

  state_t            state_r;
  phase_t            phase_r;
  mode_t             mode_r;
  logic [POS_W-1:0]  position_r;
  logic [15:0]       poll_count_r;
  logic [WAIT_W-1:0] wait_left_r;
  logic [7:0]        rdata_r;
  logic              out_valid_r;
  logic [2:0]        out_action_r;
  logic [15:0]       out_address_r;
  logic [7:0]        out_write_data_r;

  eval_t             ev;
  logic              pos_over;
  logic [WAIT_W-1:0] wait_dec;
  logic [POS_W-1:0]  position_inc;

  psi_eval u_eval (
    .entry (entry),
    .cfg   (cfg),
    .rdata (rdata_r),
    .ev    (ev)
  );

  assign raddr        = position_r[IDX_W-1:0];
  assign busy         = (state_r != ST_IDLE);
  assign pos_over     = (position_r >= POS_W'(TABLE_DEPTH));
  assign wait_dec     = (wait_left_r != '0) ? wait_left_r - WAIT_W'(1) : wait_left_r;
  assign position_inc = position_r + POS_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= PH_IDLE;
      mode_r       <= MD_SCAN;
      position_r   <= '0;
      poll_count_r <= '0;
      wait_left_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (req.valid) begin
            case (req.command)
              CMD_START: begin
                position_r   <= '0;
                poll_count_r <= '0;
                wait_left_r  <= '0;
                mode_r       <= MD_SCAN;
                state_r      <= ST_FETCH;
              end
              CMD_RDATA: begin
                if (!pos_over && (phase_r == PH_WREAD || phase_r == PH_PREAD)) begin
                  rdata_r <= req.read_data;
                  mode_r  <= MD_RDATA;
                  state_r <= ST_FETCH;
                end
              end
              CMD_TICK: begin
                if (phase_r == PH_RUN) begin
                  mode_r  <= MD_SCAN;
                  state_r <= ST_FETCH;
                end else if (phase_r == PH_PWAIT || phase_r == PH_DELAY) begin
                  wait_left_r <= wait_dec;
                  if (wait_dec == '0) begin
                    if (phase_r == PH_DELAY) begin
                      position_r <= position_inc;
                      mode_r     <= MD_SCAN;
                      state_r    <= ST_FETCH;
                    end else if (pos_over) begin
                      phase_r <= PH_IDLE;
                    end else begin
                      mode_r  <= MD_PREREAD;
                      state_r <= ST_FETCH;
                    end
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_FETCH: begin
          // table read address is presented this cycle
          if (mode_r == MD_SCAN && pos_over) begin
            out_valid_r      <= 1'b1;
            out_action_r     <= ACT_OVERRUN;
            out_address_r    <= '0;
            out_write_data_r <= '0;
            phase_r          <= PH_IDLE;
            state_r          <= ST_IDLE;
          end else begin
            state_r <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          out_address_r    <= entry.offset;
          out_write_data_r <= '0;
          state_r          <= ST_IDLE;
          case (mode_r)
            MD_SCAN: begin
              if (ev.match && entry.op == OP_WRITE) begin
                phase_r      <= PH_WREAD;
                out_valid_r  <= 1'b1;
                out_action_r <= ACT_READ;
              end else if (ev.match && entry.op == OP_POLL) begin
                phase_r      <= PH_PREAD;
                out_valid_r  <= 1'b1;
                out_action_r <= ACT_READ;
              end else if (ev.match && entry.op == OP_DELAY && ev.delay_ticks != '0) begin
                wait_left_r <= ev.delay_ticks;
                phase_r     <= PH_DELAY;
              end else if (ev.match && entry.op == OP_END) begin
                phase_r       <= PH_IDLE;
                out_valid_r   <= 1'b1;
                out_action_r  <= ACT_DONE;
                out_address_r <= '0;
              end else begin
                // skipped entry, move to the next slot
                position_r <= position_inc;
                state_r    <= ST_FETCH;
              end
            end
            MD_RDATA: begin
              if (phase_r == PH_WREAD) begin
                position_r       <= position_inc;
                phase_r          <= PH_RUN;
                out_valid_r      <= 1'b1;
                out_action_r     <= ACT_WRITE;
                out_write_data_r <= ev.merged;
              end else begin
                if (poll_count_r != 16'hFFFF) begin
                  poll_count_r <= poll_count_r + 16'd1;
                end
                if (poll_count_r > cfg.poll_limit) begin
                  phase_r      <= PH_IDLE;
                  out_valid_r  <= 1'b1;
                  out_action_r <= ACT_TIMEOUT;
                end else if (ev.hit) begin
                  position_r <= position_inc;
                  mode_r     <= MD_SCAN;
                  state_r    <= ST_FETCH;
                end else if (cfg.poll_wait_ticks == '0) begin
                  out_valid_r  <= 1'b1;
                  out_action_r <= ACT_READ;
                end else begin
                  wait_left_r <= WAIT_W'(cfg.poll_wait_ticks);
                  phase_r     <= PH_PWAIT;
                end
              end
            end
            MD_PREREAD: begin
              phase_r      <= PH_PREAD;
              out_valid_r  <= 1'b1;
              out_action_r <= ACT_READ;
            end
            default: begin
            end
          endcase
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_action     = out_action_r;
  assign out_address    = out_address_r;
  assign out_write_data = out_write_data_r;

endmodule

// ----- design/power_sequence_interpreter_unit.sv -----
// Top level of the power sequence interpreter: configuration registers, entry table,
// sequencer. Depends on psi_pkg, psi_ram, psi_seq.
//
// A command is taken when start is high and busy is low. Loads and ticks that only count
// down finish in the cycle they are taken and leave busy low. Start, read data and ticks
// that resume the sequence hold busy high while the sequencer walks the table, visiting
// each entry as a table read address step followed by evaluation of the registered read
// data; a scan that runs off the end of the table reports the overrun from the read
// address step. Each result is shown for a single cycle with out_valid high and must be
// taken then; there is no way to hold it off. Configuration writes are always ready and
// should only be made while no sequence is in progress.
module power_sequence_interpreter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [4:0]  in_entry_index,
  input  logic [15:0] in_entry_offset,
  input  logic [7:0]  in_entry_cut,
  input  logic [7:0]  in_entry_fab,
  input  logic [7:0]  in_entry_intf,
  input  logic [2:0]  in_entry_op,
  input  logic [7:0]  in_entry_mask,
  input  logic [7:0]  in_entry_value,
  input  logic [7:0]  in_read_data,
  output logic        out_valid,
  output logic [2:0]  out_action,
  output logic [15:0] out_address,
  output logic [7:0]  out_write_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import psi_pkg::*;

  cfg_t             cfg_r;
  req_t             req;
  entry_t           wr_entry;
  entry_t           rd_entry;
  logic [IDX_W-1:0] raddr;
  logic             in_xfer;
  logic             seq_busy;

  assign cfg_ready = 1'b1;
  assign in_xfer   = start && !seq_busy;
  assign busy      = seq_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cut_version     <= CUT_RESET;
      cfg_r.fab_version     <= FAB_RESET;
      cfg_r.host_intf       <= INTF_RESET;
      cfg_r.poll_limit      <= POLL_LIMIT_RESET;
      cfg_r.poll_wait_ticks <= POLL_WAIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CUT_VERSION:     cfg_r.cut_version     <= cfg_data[7:0];
        REG_FAB_VERSION:     cfg_r.fab_version     <= cfg_data[7:0];
        REG_HOST_INTF:       cfg_r.host_intf       <= cfg_data[7:0];
        REG_POLL_LIMIT:      cfg_r.poll_limit      <= cfg_data;
        REG_POLL_WAIT_TICKS: cfg_r.poll_wait_ticks <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    wr_entry.offset = in_entry_offset;
    wr_entry.cut    = in_entry_cut;
    wr_entry.fab    = in_entry_fab;
    wr_entry.intf   = in_entry_intf;
    wr_entry.op     = in_entry_op;
    wr_entry.mask   = in_entry_mask;
    wr_entry.value  = in_entry_value;
    req.valid       = in_xfer;
    req.command     = in_command;
    req.read_data   = in_read_data;
  end

  psi_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (in_xfer && in_command == CMD_LOAD),
    .waddr (in_entry_index[IDX_W-1:0]),
    .wdata (wr_entry),
    .raddr (raddr),
    .rdata (rd_entry)
  );

  psi_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .req            (req),
    .cfg            (cfg_r),
    .entry          (rd_entry),
    .raddr          (raddr),
    .busy           (seq_busy),
    .out_valid      (out_valid),
    .out_action     (out_action),
    .out_address    (out_address),
    .out_write_data (out_write_data)
  );

endmodule
